>>> rtl/nearest_point_with_bearing_macros.svh
// Assertion macros shared by the checkers of the nearest point block.
// Included by npb_checker.sv; depends on nothing else.
`ifndef NEAREST_POINT_WITH_BEARING_MACROS_SVH
`define NEAREST_POINT_WITH_BEARING_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NPB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("npb check failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define NPB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("npb check failed: next-cycle implication");

`endif

>>> rtl/npb_pkg.sv
// Package of the nearest point with bearing block: widths, CORDIC constants,
// the arctangent table and the types passed between front and back.
`timescale 1ns / 1ps

package npb_pkg;

    localparam int COORD_W       = 16;
    localparam int INDEX_W       = 10;
    localparam int BEARING_W     = 16;
    localparam int DIST_W        = 32;
    localparam int CORDIC_STEPS  = 14;
    localparam int SCALE_SHIFT   = 14;
    localparam int CORDIC_W      = 33;
    localparam int ANGLE_W       = 17;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);
    localparam int INDEX_MAX     = (1 << INDEX_W) - 1;

    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q = ANGLE_W'(12868);
    localparam logic signed [ANGLE_W-1:0] PI_Q      = ANGLE_W'(25736);

    // One finished scan, waiting for its bearing.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [INDEX_W-1:0]        pos;
        logic                      has_point;
    } npb_job_t;

    // Contents of one CORDIC pipeline stage.
    typedef struct packed {
        logic signed [CORDIC_W-1:0] cx;
        logic signed [CORDIC_W-1:0] cy;
        logic signed [ANGLE_W-1:0]  angle;
        logic                       origin;
        npb_job_t                   job;
    } npb_stage_t;

    // atan(2^-i) in radians times 8192, rounded to nearest.
    function automatic logic signed [ANGLE_W-1:0] atan_lut(input int idx);
        logic signed [ANGLE_W-1:0] val;
        case (idx)
            0:       val = ANGLE_W'(6434);
            1:       val = ANGLE_W'(3798);
            2:       val = ANGLE_W'(2007);
            3:       val = ANGLE_W'(1019);
            4:       val = ANGLE_W'(511);
            5:       val = ANGLE_W'(256);
            6:       val = ANGLE_W'(128);
            7:       val = ANGLE_W'(64);
            8:       val = ANGLE_W'(32);
            9:       val = ANGLE_W'(16);
            10:      val = ANGLE_W'(8);
            11:      val = ANGLE_W'(4);
            12:      val = ANGLE_W'(2);
            13:      val = ANGLE_W'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

>>> rtl/npb_point_if.sv
// Channel of incoming scan points: valid/ready handshake plus point payload.
// Depends on npb_pkg.
`timescale 1ns / 1ps

interface npb_point_if;
    import npb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      point_present;
    logic                      last_point;

    modport source (output valid, output point_x, output point_y,
                    output point_present, output last_point, input ready);
    modport sink   (input valid, input point_x, input point_y,
                    input point_present, input last_point, output ready);
endinterface

>>> rtl/npb_answer_if.sv
// Channel of per-scan answers: valid/ready handshake plus nearest point,
// bearing and index. Depends on npb_pkg.
`timescale 1ns / 1ps

interface npb_answer_if;
    import npb_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [COORD_W-1:0]   nearest_x;
    logic signed [COORD_W-1:0]   nearest_y;
    logic signed [BEARING_W-1:0] nearest_bearing;
    logic [INDEX_W-1:0]          nearest_index;

    modport source (output valid, output nearest_x, output nearest_y,
                    output nearest_bearing, output nearest_index, input ready);
    modport sink   (input valid, input nearest_x, input nearest_y,
                    input nearest_bearing, input nearest_index, output ready);
endinterface

>>> rtl/npb_front.sv
// Front end: takes point beats, squares the coordinates, keeps the running
// minimum per scan and emits one job per scan end. Depends on npb_pkg.
`timescale 1ns / 1ps

module npb_front #(
    parameter int MAX_POINTS = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    npb_point_if.sink         points,
    input  logic              room,
    output logic              push,
    output npb_pkg::npb_job_t push_job
);
    import npb_pkg::*;

    localparam int LIMIT = (MAX_POINTS - 1 < INDEX_MAX) ? MAX_POINTS - 1 : INDEX_MAX;
    localparam logic [INDEX_W-1:0] LIMIT_IDX = INDEX_W'(LIMIT);

    logic                      accept;
    logic [COORD_W-1:0]        abs_x;
    logic [COORD_W-1:0]        abs_y;

    logic                      a_valid_reg;
    logic signed [COORD_W-1:0] a_x_reg;
    logic signed [COORD_W-1:0] a_y_reg;
    logic                      a_present_reg;
    logic                      a_last_reg;
    logic [DIST_W-1:0]         a_xsq_reg;
    logic [DIST_W-1:0]         a_ysq_reg;

    logic [DIST_W-1:0]         best_dist_reg, best_dist_next;
    logic signed [COORD_W-1:0] best_x_reg, best_x_next;
    logic signed [COORD_W-1:0] best_y_reg, best_y_next;
    logic [INDEX_W-1:0]        best_pos_reg, best_pos_next;
    logic [INDEX_W-1:0]        counter_reg, counter_next;
    logic                      has_point_reg, has_point_next;

    logic [DIST_W-1:0]         dist_sq;
    logic                      take;

    assign points.ready = room;
    assign accept       = points.valid && room;
    assign abs_x = points.point_x[COORD_W-1] ? COORD_W'(-points.point_x) : points.point_x;
    assign abs_y = points.point_y[COORD_W-1] ? COORD_W'(-points.point_y) : points.point_y;

    // Stage A: register the squares.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_x_reg       <= points.point_x;
            a_y_reg       <= points.point_y;
            a_present_reg <= points.point_present;
            a_last_reg    <= points.last_point;
            a_xsq_reg     <= DIST_W'(abs_x) * DIST_W'(abs_x);
            a_ysq_reg     <= DIST_W'(abs_y) * DIST_W'(abs_y);
        end
    end

    // Stage B: add, compare against the running best, close the scan.
    assign dist_sq = a_xsq_reg + a_ysq_reg;
    assign take = a_valid_reg && a_present_reg && (!has_point_reg || dist_sq < best_dist_reg);

    always_comb
    begin
        best_dist_next = best_dist_reg;
        best_x_next    = best_x_reg;
        best_y_next    = best_y_reg;
        best_pos_next  = best_pos_reg;
        counter_next   = counter_reg;
        has_point_next = has_point_reg;
        if (take)
        begin
            best_dist_next = dist_sq;
            best_x_next    = a_x_reg;
            best_y_next    = a_y_reg;
            best_pos_next  = counter_reg;
        end
        if (a_valid_reg && a_present_reg)
        begin
            has_point_next = 1'b1;
            if (counter_reg < LIMIT_IDX)
            begin
                counter_next = counter_reg + 1'b1;
            end
        end
        if (a_valid_reg && a_last_reg)
        begin
            best_dist_next = '1;
            counter_next   = '0;
            has_point_next = 1'b0;
        end
    end

    assign push               = a_valid_reg && a_last_reg;
    assign push_job.x         = best_x_next;
    assign push_job.y         = best_y_next;
    assign push_job.pos       = best_pos_next;
    assign push_job.has_point = has_point_reg || a_present_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_dist_reg <= '1;
            best_x_reg    <= '0;
            best_y_reg    <= '0;
            best_pos_reg  <= '0;
            counter_reg   <= '0;
            has_point_reg <= 1'b0;
        end
        else
        begin
            best_dist_reg <= best_dist_next;
            best_x_reg    <= best_x_next;
            best_y_reg    <= best_y_next;
            best_pos_reg  <= best_pos_next;
            counter_reg   <= counter_next;
            has_point_reg <= has_point_next;
        end
    end

endmodule

>>> rtl/npb_queue.sv
// Short job queue between front and back so that each side stalls alone.
// Depends on npb_pkg.
`timescale 1ns / 1ps

module npb_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  npb_pkg::npb_job_t push_job,
    input  logic              pop,
    output logic              head_valid,
    output npb_pkg::npb_job_t head_job,
    output logic              room
);
    import npb_pkg::*;

    npb_job_t            mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic                do_pop;

    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;
    // Two free slots: one for a scan end already in the front pipeline,
    // one for the beat being accepted now.
    assign room       = (count_reg <= QUEUE_CW'(QUEUE_DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> rtl/npb_back.sv
// Back end: pipelined vectoring CORDIC for the bearing, held answer and the
// output register. Depends on npb_pkg and npb_answer_if.
`timescale 1ns / 1ps

module npb_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  npb_pkg::npb_job_t job,
    output logic              pop,
    npb_answer_if.source      answer
);
    import npb_pkg::*;

    logic                        advance;
    logic                        out_valid_reg;
    logic signed [COORD_W-1:0]   held_x_reg;
    logic signed [COORD_W-1:0]   held_y_reg;
    logic signed [BEARING_W-1:0] held_bearing_reg;
    logic [INDEX_W-1:0]          held_index_reg;

    logic                        valid_reg [CORDIC_STEPS + 1];
    npb_stage_t                  stage_reg [CORDIC_STEPS + 1];
    npb_stage_t                  stage_next [CORDIC_STEPS + 1];

    logic signed [CORDIC_W-1:0]  in_cx;
    logic signed [CORDIC_W-1:0]  in_cy;
    logic signed [ANGLE_W-1:0]   final_angle;
    logic signed [BEARING_W-1:0] bearing;

    // The whole pipeline moves together whenever the output slot frees up.
    assign advance = !out_valid_reg || answer.ready;
    assign pop     = advance;

    assign in_cx = {{(CORDIC_W - COORD_W - SCALE_SHIFT){job.x[COORD_W-1]}},
                    job.x, {SCALE_SHIFT{1'b0}}};
    assign in_cy = {{(CORDIC_W - COORD_W - SCALE_SHIFT){job.y[COORD_W-1]}},
                    job.y, {SCALE_SHIFT{1'b0}}};

    // Entry: points in the left half plane are turned by a quarter turn.
    always_comb
    begin
        stage_next[0].job    = job;
        stage_next[0].origin = (job.x == '0) && (job.y == '0);
        if (in_cx < 0)
        begin
            if (in_cy >= 0)
            begin
                stage_next[0].cx    = in_cy;
                stage_next[0].cy    = -in_cx;
                stage_next[0].angle = HALF_PI_Q;
            end
            else
            begin
                stage_next[0].cx    = -in_cy;
                stage_next[0].cy    = in_cx;
                stage_next[0].angle = -HALF_PI_Q;
            end
        end
        else
        begin
            stage_next[0].cx    = in_cx;
            stage_next[0].cy    = in_cy;
            stage_next[0].angle = '0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        always_comb
        begin
            stage_next[i+1] = stage_reg[i];
            if (stage_reg[i].cy >= 0)
            begin
                stage_next[i+1].cx    = stage_reg[i].cx + (stage_reg[i].cy >>> i);
                stage_next[i+1].cy    = stage_reg[i].cy - (stage_reg[i].cx >>> i);
                stage_next[i+1].angle = stage_reg[i].angle + atan_lut(i);
            end
            else
            begin
                stage_next[i+1].cx    = stage_reg[i].cx - (stage_reg[i].cy >>> i);
                stage_next[i+1].cy    = stage_reg[i].cy + (stage_reg[i].cx >>> i);
                stage_next[i+1].angle = stage_reg[i].angle - atan_lut(i);
            end
        end
    end

    for (genvar s = 0; s <= CORDIC_STEPS; s++)
    begin : g_stage
        if (s == 0)
        begin : g_head
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else if (advance)
                begin
                    valid_reg[s] <= job_valid;
                end
            end
        end
        else
        begin : g_tail
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else if (advance)
                begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

    assign final_angle = stage_reg[CORDIC_STEPS].angle;

    always_comb
    begin
        if (stage_reg[CORDIC_STEPS].origin)
        begin
            bearing = '0;
        end
        else if (final_angle > PI_Q)
        begin
            bearing = BEARING_W'(PI_Q);
        end
        else if (final_angle < -PI_Q)
        begin
            bearing = BEARING_W'(-PI_Q);
        end
        else
        begin
            bearing = BEARING_W'(final_angle);
        end
    end

    // The held answer doubles as the output register; an empty scan repeats it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            held_x_reg       <= '0;
            held_y_reg       <= '0;
            held_bearing_reg <= '0;
            held_index_reg   <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= valid_reg[CORDIC_STEPS];
            if (valid_reg[CORDIC_STEPS] && stage_reg[CORDIC_STEPS].job.has_point)
            begin
                held_x_reg       <= stage_reg[CORDIC_STEPS].job.x;
                held_y_reg       <= stage_reg[CORDIC_STEPS].job.y;
                held_bearing_reg <= bearing;
                held_index_reg   <= stage_reg[CORDIC_STEPS].job.pos;
            end
        end
    end

    assign answer.valid           = out_valid_reg;
    assign answer.nearest_x       = held_x_reg;
    assign answer.nearest_y       = held_y_reg;
    assign answer.nearest_bearing = held_bearing_reg;
    assign answer.nearest_index   = held_index_reg;

endmodule

>>> rtl/nearest_point_with_bearing.sv
// A scan end passes through the front stage A registers, the queue, the entry
// stage plus 14 CORDIC stages and the output register before its answer is valid.
// One point beat per cycle while the queue has room, one answer beat per cycle
// while the answer side is ready: the squaring multipliers take a beat a cycle
// with room, the 14-stage CORDIC pipeline while the output slot is free.
// Reset (rst_n, asynchronous, active low) empties queue and pipeline and
// clears the held answer to zero; the block accepts beats right after reset.
`timescale 1ns / 1ps

module nearest_point_with_bearing #(
    parameter int MAX_POINTS = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    npb_point_if.sink     points,
    npb_answer_if.source  answer
);
    import npb_pkg::*;

    // The front end squares each point, keeps the least squared distance of
    // the open scan (strictly less wins, so the earlier point keeps a tie)
    // and counts the point index, saturating at the smaller of MAX_POINTS-1 and 1023.
    // A scan-end beat packs the winner into a job for the queue.
    logic     push;
    npb_job_t push_job;
    logic     room;
    logic     pop;
    logic     head_valid;
    npb_job_t head_job;

    npb_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .points   (points),
        .room     (room),
        .push     (push),
        .push_job (push_job)
    );

    // The queue absorbs scan ends while the answer side is stalled. The
    // front stops taking beats when fewer than two slots remain, which
    // covers a scan end still inside the front pipeline.
    npb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job),
        .room       (room)
    );

    // The back end runs the bearing through a vectoring CORDIC, one rotation
    // per stage, then updates the held answer. A scan without points passes
    // through too and simply repeats the held answer.
    npb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (head_valid),
        .job       (head_job),
        .pop       (pop),
        .answer    (answer)
    );

endmodule

>>> rtl/npb_checker.sv
// Port-level checker for nearest_point_with_bearing, bound to the top level.
// Depends on npb_pkg and nearest_point_with_bearing_macros.svh.
`timescale 1ns / 1ps
`include "nearest_point_with_bearing_macros.svh"

module npb_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [npb_pkg::COORD_W-1:0]   nearest_x,
    input logic signed [npb_pkg::COORD_W-1:0]   nearest_y,
    input logic signed [npb_pkg::BEARING_W-1:0] nearest_bearing,
    input logic [npb_pkg::INDEX_W-1:0]          nearest_index
);
    import npb_pkg::*;

    // A stalled answer beat keeps its whole payload.
    `NPB_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(nearest_x) && $stable(nearest_y) && $stable(nearest_bearing) && $stable(nearest_index))

    // The bearing never leaves the clamped range of plus or minus pi.
    `NPB_ASSERT_IMP(a_range, clk, rst_n, out_valid, nearest_bearing <= BEARING_W'(PI_Q) && nearest_bearing >= -BEARING_W'(PI_Q))

    // The origin, including the answer held since reset, has bearing zero.
    `NPB_ASSERT_IMP(a_origin, clk, rst_n, out_valid && nearest_x == '0 && nearest_y == '0, nearest_bearing == '0)

endmodule

bind nearest_point_with_bearing npb_checker u_npb_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (answer.valid),
    .out_ready       (answer.ready),
    .nearest_x       (answer.nearest_x),
    .nearest_y       (answer.nearest_y),
    .nearest_bearing (answer.nearest_bearing),
    .nearest_index   (answer.nearest_index)
);

>>> sim/nearest_point_with_bearing_tb.sv
// Self-checking testbench for nearest_point_with_bearing: scans of points go in
// on the point channel and per-scan answers are checked against a local predictor.
// Depends on npb_pkg, npb_point_if, npb_answer_if and the block itself.
`timescale 1ns / 1ps

module nearest_point_with_bearing_tb;
    import npb_pkg::*;

    // Size the block is built with. It sets where the point index saturates.
    localparam int MAX_POINTS    = 1024;
    localparam int INDEX_LIMIT   = (MAX_POINTS - 1 < INDEX_MAX) ? MAX_POINTS - 1 : INDEX_MAX;
    localparam int DIRECTED_ROWS = 25;
    localparam int PHASE_ITEMS   = 110;    // counted beats per idling phase
    localparam int LONG_SCAN     = 1030;   // points in the scan that saturates the index
    localparam int DRAIN_CYCLES  = 40;     // margin after the last owed answer for stray answer beats
    localparam int LIMIT_NS      = 3000000;

    // atan(2^-i) in radians times 8192, rounded to nearest.
    localparam int ATAN_Q13 [CORDIC_STEPS] =
        '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      present;
        logic                      last;
    } point_beat_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]   x;
        logic signed [COORD_W-1:0]   y;
        logic signed [BEARING_W-1:0] bearing;
        logic [INDEX_W-1:0]          index;
    } scan_answer_t;

    typedef struct {
        point_beat_t  beat;
        bit           fixed;     // answer below is typed in, not predicted
        scan_answer_t answer;
    } directed_row_t;

    localparam scan_answer_t ZERO_ANSWER = '0;

    logic clk;
    logic rst_n;

    npb_point_if  pts ();
    npb_answer_if ans ();

    nearest_point_with_bearing #(
        .MAX_POINTS (MAX_POINTS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .points (pts),
        .answer (ans)
    );

    // The directed rows come first. Only the answers that are plainly zero are
    // typed in: the empty scan straight after reset, the point at the origin and
    // an empty scan that repeats that held answer. Every other answer, the
    // clamped bearings near plus and minus pi and the ties included, comes
    // from the predictor.
    directed_row_t plan [DIRECTED_ROWS] = '{
        '{'{0, 0, 1'b0, 1'b1},           1'b1, ZERO_ANSWER},
        '{'{0, 0, 1'b1, 1'b1},           1'b1, ZERO_ANSWER},
        '{'{1234, -77, 1'b0, 1'b0},      1'b0, ZERO_ANSWER},
        '{'{-4321, 99, 1'b0, 1'b1},      1'b1, ZERO_ANSWER},
        '{'{32767, 32767, 1'b1, 1'b0},   1'b0, ZERO_ANSWER},
        '{'{-32768, -32768, 1'b1, 1'b0}, 1'b0, ZERO_ANSWER},
        '{'{-32768, 32767, 1'b1, 1'b0},  1'b0, ZERO_ANSWER},
        '{'{32767, -32768, 1'b1, 1'b1},  1'b0, ZERO_ANSWER},
        '{'{-32768, 0, 1'b1, 1'b1},      1'b0, ZERO_ANSWER},
        '{'{-32768, -1, 1'b1, 1'b1},     1'b0, ZERO_ANSWER},
        '{'{0, 32767, 1'b1, 1'b1},       1'b0, ZERO_ANSWER},
        '{'{0, -32768, 1'b1, 1'b1},      1'b0, ZERO_ANSWER},
        '{'{-1, 0, 1'b1, 1'b1},          1'b0, ZERO_ANSWER},
        '{'{3, 4, 1'b1, 1'b0},           1'b0, ZERO_ANSWER},
        '{'{-4, 3, 1'b1, 1'b0},          1'b0, ZERO_ANSWER},
        '{'{0, -5, 1'b1, 1'b0},          1'b0, ZERO_ANSWER},
        '{'{5, 0, 1'b0, 1'b0},           1'b0, ZERO_ANSWER},
        '{'{-5, 0, 1'b1, 1'b1},          1'b0, ZERO_ANSWER},
        '{'{777, 777, 1'b0, 1'b1},       1'b0, ZERO_ANSWER},
        '{'{900, -900, 1'b1, 1'b0},      1'b0, ZERO_ANSWER},
        '{'{0, 0, 1'b0, 1'b0},           1'b0, ZERO_ANSWER},
        '{'{2, -3, 1'b1, 1'b0},          1'b0, ZERO_ANSWER},
        '{'{0, 1, 1'b0, 1'b1},           1'b0, ZERO_ANSWER},
        '{'{-7, -7, 1'b1, 1'b1},         1'b0, ZERO_ANSWER},
        '{'{-1, -1, 1'b1, 1'b1},         1'b0, ZERO_ANSWER}
    };

    // Predictor state, a copy of what the block keeps between beats.
    longint                    best_dist_sq;
    logic signed [COORD_W-1:0] best_x;
    logic signed [COORD_W-1:0] best_y;
    logic [INDEX_W-1:0]        best_pos;
    logic [INDEX_W-1:0]        next_pos;
    bit                        scan_has_point;
    scan_answer_t              held_answer;

    // Answers the block still owes, oldest first.
    scan_answer_t answers_due [$];

    int send_idle_pct;
    int recv_stall_pct;
    int beats_sent;
    int answers_checked;
    int mismatches;

    // Bearing by vectoring CORDIC in Q13 radians. Points in the left half plane
    // are first turned a quarter turn so the iterations start with x >= 0; the
    // shifts are arithmetic, so they round toward minus infinity.
    function automatic logic signed [BEARING_W-1:0] bearing_q13(
        input logic signed [COORD_W-1:0] px,
        input logic signed [COORD_W-1:0] py
    );
        longint cx;
        longint cy;
        longint nx;
        longint ny;
        longint acc;
        acc = 0;
        if (px == 0 && py == 0)
        begin
            return '0;
        end
        cx = longint'(px) <<< SCALE_SHIFT;
        cy = longint'(py) <<< SCALE_SHIFT;
        if (cx < 0)
        begin
            if (cy >= 0)
            begin
                nx  = cy;
                ny  = -cx;
                acc = HALF_PI_Q;
            end
            else
            begin
                nx  = -cy;
                ny  = cx;
                acc = -HALF_PI_Q;
            end
            cx = nx;
            cy = ny;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (cy >= 0)
            begin
                nx  = cx + (cy >>> i);
                ny  = cy - (cx >>> i);
                acc = acc + ATAN_Q13[i];
            end
            else
            begin
                nx  = cx - (cy >>> i);
                ny  = cy + (cx >>> i);
                acc = acc - ATAN_Q13[i];
            end
            cx = nx;
            cy = ny;
        end
        if (acc > PI_Q)
        begin
            acc = PI_Q;
        end
        if (acc < -PI_Q)
        begin
            acc = -PI_Q;
        end
        return BEARING_W'(acc);
    endfunction

    // Folds one accepted beat into the running nearest-point search. Returns 1
    // when the beat ends a scan, with the answer the block has to give for it.
    function automatic bit track_nearest(input point_beat_t b, output scan_answer_t a);
        longint d;
        a = held_answer;
        if (b.present)
        begin
            d = longint'(b.x) * b.x + longint'(b.y) * b.y;
            // Strictly nearer only, so on a tie the earlier point stays.
            if (!scan_has_point || d < best_dist_sq)
            begin
                best_dist_sq = d;
                best_x       = b.x;
                best_y       = b.y;
                best_pos     = next_pos;
            end
            scan_has_point = 1'b1;
            if (next_pos < INDEX_LIMIT)
            begin
                next_pos = next_pos + 1'b1;
            end
        end
        if (!b.last)
        begin
            return 1'b0;
        end
        // A scan without points repeats whatever answer is held.
        if (scan_has_point)
        begin
            held_answer.x       = best_x;
            held_answer.y       = best_y;
            held_answer.bearing = bearing_q13(best_x, best_y);
            held_answer.index   = best_pos;
        end
        best_dist_sq   = -1;
        next_pos       = '0;
        scan_has_point = 1'b0;
        a = held_answer;
        return 1'b1;
    endfunction

    // Coordinates spread over the whole range, small and medium magnitudes for
    // close contests, and the extreme codes.
    function automatic logic signed [COORD_W-1:0] rand_coord();
        int v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = int'($urandom_range(65535)) - 32768;
            4, 5:       v = int'($urandom_range(128)) - 64;
            6, 7:       v = int'($urandom_range(4096)) - 2048;
            default:
            begin
                case ($urandom_range(5))
                    0:       v = -32768;
                    1:       v = -32767;
                    2:       v = -1;
                    3:       v = 0;
                    4:       v = 1;
                    default: v = 32767;
                endcase
            end
        endcase
        return COORD_W'(v);
    endfunction

    // Drives one point beat from the falling edge, with random idle cycles
    // ahead of it, and holds it until the block takes it at a rising edge.
    // The expected answer, if the beat ends a scan, is queued on acceptance.
    task automatic push_beat(input point_beat_t b, input bit fixed, input scan_answer_t fixed_answer);
        scan_answer_t predicted;
        bit           ends_scan;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pts.valid = 1'b0;
            @(negedge clk);
        end
        pts.valid         = 1'b1;
        pts.point_x       = b.x;
        pts.point_y       = b.y;
        pts.point_present = b.present;
        pts.last_point    = b.last;
        do
        begin
            @(posedge clk);
        end
        while (!pts.ready);
        ends_scan = track_nearest(b, predicted);
        if (ends_scan)
        begin
            answers_due.push_back(fixed ? fixed_answer : predicted);
        end
        if (b.present || b.last)
        begin
            beats_sent++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Answer side: ready is redrawn at every falling edge from the stall rate
    // of the current phase.
    initial
    begin
        ans.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            ans.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every answer beat is checked field by field against the oldest
    // expectation; an answer with nothing pending is a failure in itself.
    initial
    begin
        scan_answer_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && ans.valid && ans.ready)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("answer beat with no scan pending: x %0d y %0d bearing %0d index %0d",
                           ans.nearest_x, ans.nearest_y, ans.nearest_bearing, ans.nearest_index);
                    mismatches++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    answers_checked++;
                    if (ans.nearest_x !== want.x)
                    begin
                        $error("nearest_x: expected %0d, got %0d", want.x, ans.nearest_x);
                        mismatches++;
                    end
                    if (ans.nearest_y !== want.y)
                    begin
                        $error("nearest_y: expected %0d, got %0d", want.y, ans.nearest_y);
                        mismatches++;
                    end
                    if (ans.nearest_bearing !== want.bearing)
                    begin
                        $error("nearest_bearing: expected %0d, got %0d",
                               want.bearing, ans.nearest_bearing);
                        mismatches++;
                    end
                    if (ans.nearest_index !== want.index)
                    begin
                        $error("nearest_index: expected %0d, got %0d",
                               want.index, ans.nearest_index);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(LIMIT_NS);
        $display("nearest_point_with_bearing_tb failed");
        $finish;
    end

    initial
    begin
        point_beat_t b;
        int          phase_sent;
        int          len;
        int          mag;
        bit          closed;

        // Known values on every input from time zero.
        rst_n             = 1'b0;
        pts.valid         = 1'b0;
        pts.point_x       = '0;
        pts.point_y       = '0;
        pts.point_present = 1'b0;
        pts.last_point    = 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        beats_sent        = 0;
        answers_checked   = 0;
        mismatches        = 0;

        // The predictor starts from the reset state of the block.
        best_dist_sq   = -1;
        best_x         = '0;
        best_y         = '0;
        best_pos       = '0;
        next_pos       = '0;
        scan_has_point = 1'b0;
        held_answer    = ZERO_ANSWER;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows, with no idling on either side.
        foreach (plan[r])
        begin
            push_beat(plan[r].beat, plan[r].fixed, plan[r].answer);
        end

        // Random scans in four idling phases: none, sender gaps, receiver
        // stalls, then both at once.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase

            // One scan longer than the index range. Its last ten points lie close
            // to the origin, most of them past the saturation point, so the nearest point
            // usually ends up at the saturated index.
            if (ph == 1)
            begin
                for (int k = 0; k < LONG_SCAN; k++)
                begin
                    if (k < LONG_SCAN - 10)
                    begin
                        mag = $urandom_range(4096, 32767);
                        b.x = COORD_W'($urandom_range(1) ? -mag : mag);
                        b.y = rand_coord();
                    end
                    else
                    begin
                        b.x = COORD_W'(int'($urandom_range(6)) - 3);
                        b.y = COORD_W'(int'($urandom_range(6)) - 3);
                    end
                    b.present = 1'b1;
                    b.last    = (k == LONG_SCAN - 1);
                    push_beat(b, 1'b0, ZERO_ANSWER);
                end
            end

            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 8)
                begin
                    // Empty scan: the end mark alone, with junk coordinates.
                    b.x       = rand_coord();
                    b.y       = rand_coord();
                    b.present = 1'b0;
                    b.last    = 1'b1;
                    push_beat(b, 1'b0, ZERO_ANSWER);
                    phase_sent++;
                end
                else
                begin
                    len    = $urandom_range(1, 12);
                    closed = 1'b0;
                    for (int k = 0; k < len; k++)
                    begin
                        // Now and then an empty beat inside the scan, which
                        // the block has to ignore.
                        if ($urandom_range(9) == 0)
                        begin
                            b.x       = rand_coord();
                            b.y       = rand_coord();
                            b.present = 1'b0;
                            b.last    = 1'b0;
                            push_beat(b, 1'b0, ZERO_ANSWER);
                        end
                        b.x       = rand_coord();
                        b.y       = rand_coord();
                        b.present = 1'b1;
                        b.last    = (k == len - 1) && ($urandom_range(99) < 85);
                        closed    = b.last;
                        push_beat(b, 1'b0, ZERO_ANSWER);
                        phase_sent++;
                    end
                    // Some scans end with a separate end mark that has no point.
                    if (!closed)
                    begin
                        b.x       = rand_coord();
                        b.y       = rand_coord();
                        b.present = 1'b0;
                        b.last    = 1'b1;
                        push_beat(b, 1'b0, ZERO_ANSWER);
                        phase_sent++;
                    end
                end
            end
        end

        @(negedge clk);
        pts.valid = 1'b0;

        // Wait for every owed answer, then give the block time to show any
        // answer beat it should not produce.
        while (answers_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d scan answers from %0d point and end-mark beats, over four idling",
                 answers_checked, beats_sent);
        $display("phases with empty scans, ignored beats, ties, extremes and a saturated index.");
        if (mismatches == 0)
        begin
            $display("nearest_point_with_bearing_tb passed");
        end
        else
        begin
            $display("nearest_point_with_bearing_tb failed");
        end
        $finish;
    end

endmodule
